### hdl/hpd_pkg.sv
// Shared types, constants and the temperature decode for the climate-panel packet decoder.
// No dependencies; every other file of the block imports this package.
package hpd_pkg;

	// Packet geometry: byte 0 is the idle byte, the rest form the body.
	localparam int PACKET_BYTES = 7;
	localparam int LAST_POS     = PACKET_BYTES - 1;
	localparam int POS_W        = 4;
	localparam int BODY_STORED  = 6;
	localparam int BYTE_W       = 8;
	localparam int OUT_DATA_W   = 32;

	localparam logic [BYTE_W-1:0] CHECK_VALUE = 8'b1000_0001;
	localparam logic [3:0]        TEMP_OFFSET = 4'd14;
	localparam logic [3:0]        TEMP_CODE_HI = 4'hf;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_IDLE   = 2'd1,
		ST_PARITY = 2'd2,
		ST_CHECK  = 2'd3
	} status_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_TEMP_LO = 1'b0,
		CFG_TEMP_HI = 1'b1
	} cfg_reg_t;

	// Packet summary handed from the accumulator to the result stage.
	typedef struct packed {
		logic                               done;
		logic                               idle_ok;
		logic                               all_zero;
		logic                               parity_ok;
		logic [BYTE_W-1:0]                  xor_val;
		logic [BODY_STORED-1:0][BYTE_W-1:0] body;
	} pkt_sum_t;

	// Result beat, laid out from the top bit down so it maps straight onto tdata.
	typedef struct packed {
		logic [2:0] pad;
		logic [7:0] temp_second;
		logic [7:0] temp_first;
		logic       ac_off;
		logic       ac_on;
		logic       left_wheel;
		logic       auto_mode;
		logic [2:0] air_direction;
		logic [2:0] fan_speed;
		logic       connected;
		status_t    status;
	} result_t;

	// Temperature code to reported value; codes 1 and 15 are the sentinels.
	function automatic logic [7:0] temp_decode(input logic [3:0] code,
			input logic [7:0] lo_val, input logic [7:0] hi_val);
		logic [7:0] val;
		if (code == 4'd0) begin
			val = 8'd0;
		end else if (code == 4'd1) begin
			val = lo_val;
		end else if (code == TEMP_CODE_HI) begin
			val = hi_val;
		end else begin
			val = {4'd0, code} + {4'd0, TEMP_OFFSET};
		end
		return val;
	endfunction

endpackage

### hdl/hpd_accum.sv
// Byte position counter, running checks and body byte store of the packet decoder.
// Depends on hpd_pkg; feeds a packet summary to hpd_result.
module hpd_accum
	import hpd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] frame_byte,
	output logic              at_last,
	output pkt_sum_t          sum
);

	logic [POS_W-1:0]                  pos_q;
	logic [BYTE_W-1:0]                 xor_q;
	logic                              idle_ok_q;
	logic                              all_zero_q;
	logic                              parity_ok_q;
	logic [BODY_STORED-1:0][BYTE_W-1:0] body_q;

	logic                              is_idle;
	logic                              is_last;
	logic                              byte_zero;
	logic [BYTE_W-1:0]                 xor_nxt;
	logic                              idle_ok_nxt;
	logic                              all_zero_nxt;
	logic                              parity_ok_nxt;
	logic [BODY_STORED-1:0][BYTE_W-1:0] body_nxt;

	// Fold the current byte into the running checks.
	always_comb begin
		is_idle       = (pos_q == '0);
		is_last       = (pos_q == POS_W'(LAST_POS));
		byte_zero     = (frame_byte == '0);
		idle_ok_nxt   = is_idle ? byte_zero : idle_ok_q;
		all_zero_nxt  = all_zero_q & (is_idle | byte_zero);
		parity_ok_nxt = parity_ok_q & (is_idle | (^frame_byte));
		xor_nxt       = is_idle ? xor_q : (xor_q ^ frame_byte);
		for (int i = 0; i < BODY_STORED; i++) begin
			body_nxt[i] = (pos_q == POS_W'(i + 1)) ? frame_byte : body_q[i];
		end
	end

	// The next beat closes a packet; the top level gates its ready with this.
	assign at_last = is_last;

	// Summary includes the byte taken in this cycle.
	always_comb begin
		sum.done      = accept & is_last;
		sum.idle_ok   = idle_ok_nxt;
		sum.all_zero  = all_zero_nxt;
		sum.parity_ok = parity_ok_nxt;
		sum.xor_val   = xor_nxt;
		sum.body      = body_nxt;
	end

	// Position and check state; cleared after the last byte of a packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			xor_q       <= '0;
			idle_ok_q   <= 1'b0;
			all_zero_q  <= 1'b1;
			parity_ok_q <= 1'b1;
		end else if (accept) begin
			if (is_last) begin
				pos_q       <= '0;
				xor_q       <= '0;
				idle_ok_q   <= 1'b0;
				all_zero_q  <= 1'b1;
				parity_ok_q <= 1'b1;
			end else begin
				pos_q       <= pos_q + POS_W'(1);
				xor_q       <= xor_nxt;
				idle_ok_q   <= idle_ok_nxt;
				all_zero_q  <= all_zero_nxt;
				parity_ok_q <= parity_ok_nxt;
			end
		end
	end

	// Body byte store; payload only, no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			body_q <= body_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(LAST_POS))
		else $error("byte position past end of packet");
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		sum.done |=> (pos_q == '0) && all_zero_q && parity_ok_q)
		else $error("packet state not cleared after last byte");
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !is_last |=> pos_q == $past(pos_q) + POS_W'(1))
		else $error("byte position did not advance");
`endif

endmodule

### hdl/hpd_result.sv
// Status decision, field decode and output register of the packet decoder.
// Depends on hpd_pkg; takes the packet summary from hpd_accum.
module hpd_result
	import hpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  pkt_sum_t   sum,
	input  logic [7:0] temp_lo,
	input  logic [7:0] temp_hi,
	input  logic       out_ready,
	output logic       out_valid,
	output result_t    result
);

	result_t res_d;
	result_t res_q;
	logic    valid_q;
	logic    body_ok;

	// Checks in priority order: idle, offline, parity, check byte.
	always_comb begin
		res_d   = '0;
		body_ok = 1'b0;
		if (!sum.idle_ok) begin
			res_d.status = ST_IDLE;
		end else if (sum.all_zero) begin
			res_d.status = ST_OK;
		end else if (!sum.parity_ok) begin
			res_d.status = ST_PARITY;
		end else if (sum.xor_val != CHECK_VALUE) begin
			res_d.status = ST_CHECK;
		end else begin
			res_d.status = ST_OK;
			body_ok      = 1'b1;
		end
		if (body_ok) begin
			res_d.connected     = (sum.body[5] != '0);
			res_d.fan_speed     = sum.body[0][3:1];
			res_d.air_direction = sum.body[1][6:4];
			res_d.auto_mode     = sum.body[1][1];
			res_d.left_wheel    = sum.body[1][3];
			res_d.ac_on         = sum.body[2][1];
			res_d.ac_off        = sum.body[2][2];
			res_d.temp_first    = temp_decode(sum.body[4][4:1], temp_lo, temp_hi);
			res_d.temp_second   = temp_decode(sum.body[3][4:1], temp_lo, temp_hi);
		end
	end

	// Output valid: set by a finished packet, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sum.done) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (sum.done) begin
			res_q <= res_d;
		end
	end

	assign out_valid = valid_q;
	assign result    = res_q;

`ifndef NO_ASSERTIONS
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		sum.done |=> valid_q)
		else $error("finished packet produced no result beat");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		sum.done |-> !valid_q || out_ready)
		else $error("result overwritten before it was taken");
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (res_q.status != ST_OK) |-> (res_q[28:2] == '0))
		else $error("rejected packet carries decoded fields");
`endif

endmodule

### hdl/hvac_panel_packet_decoder.sv
// Output: a result beat shows on the master side in the cycle after the last packet byte is taken.
// Throughput: one byte per cycle; the output register frees the input while a result waits,
// and the input stalls only when a held result is not taken in the cycle a packet ends.
// Reset: arst_n resets the byte position, check flags and output valid at once, and sets
// the sentinel registers to 1 and 255; stored body bytes are not reset.
// Depends on hpd_pkg, hpd_accum and hpd_result.
module hvac_panel_packet_decoder
	import hpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] frame_byte
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // status, connected, fan_speed, air_direction,
	                                         // auto_mode, left_wheel, ac_on, ac_off,
	                                         // temp_first, temp_second, zero pad
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [7:0]            cfg_wdata
);

	logic       accept;
	logic       at_last;
	logic [7:0] temp_lo_q;
	logic [7:0] temp_hi_q;
	pkt_sum_t   sum;
	result_t    result;

	// Input beat taken unless it closes a packet while a held result is not drained.
	assign s_tready = !at_last || !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Sentinel registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_lo_q <= 8'd1;
			temp_hi_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP_LO: temp_lo_q <= cfg_wdata;
				CFG_TEMP_HI: temp_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hpd_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.frame_byte (s_tdata),
		.at_last    (at_last),
		.sum        (sum)
	);

	hpd_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum       (sum),
		.temp_lo   (temp_lo_q),
		.temp_hi   (temp_hi_q),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.result    (result)
	);

	assign m_tdata = result;

endmodule
